@@ hw/rtl/gmpc_pkg.sv @@
// gmpc_pkg: shared types and constants of the gaussian mixture pixel classifier
// depends on nothing; imported by every module of the block but gmpc_checker
package gmpc_pkg;

  // one mixture component as stored in the model memory
  typedef struct packed {
    logic [15:0] ratio;
    logic [15:0] weight;
    logic [15:0] std_dev;
    logic [15:0] mean;
  } entry_t;

  // request codes
  localparam logic REQ_LOAD     = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  localparam int CNT_W = 4;   // width of match rank and background count
  localparam int SUM_W = 20;  // weight sum never overflows with up to eight components

  localparam logic [15:0] BG_THRESHOLD_RESET = 16'd32768;

endpackage

@@ hw/rtl/gaussian_mixture_pixel_classifier.sv @@
// gaussian_mixture_pixel_classifier: top level of the per-pixel mixture classifier
// depends on gmpc_pkg, gmpc_model_mem, gmpc_rank_match, gmpc_decide
//
// usage
//   input channel (in_*): load items (req_type 0) write one component of one
//   pixel's model; classify items (req_type 1) produce one result each
//   result channel (out_*): pixel index, foreground flag, match rank and
//   background count of a classify item, in input order
//   config channel (cfg_*): bg_threshold, always ready, written while idle
// timing
//   three stages: model read, rank and match, sum and decide
//   one item per cycle while out_ready keeps the stages from filling, set by the
//   model banks' one read and one write per cycle
//   a load writes at its transfer; a classify transferred in the next cycle sees it
// reset
//   clears stage valids and sets bg_threshold to 0.5; model memory is not
//   cleared, a component must be loaded before its pixel is classified
// stall
//   stages hold while out_ready is low; bubbles close up, and in_ready falls
//   only when all three stages are full
//   loads with a component or pixel out of range and classifies of a pixel out
//   of range are dropped without result
module gaussian_mixture_pixel_classifier #(
  parameter int NUM_COMPONENTS = 5,
  parameter int NUM_PIXELS     = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [15:0] in_pixel_index,
  input  logic [2:0]  in_component,
  input  logic [15:0] in_mean_value,
  input  logic [15:0] in_std_value,
  input  logic [15:0] in_weight_value,
  input  logic [15:0] in_rank_ratio,
  input  logic [7:0]  in_intensity,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pixel_out,
  output logic        out_foreground,
  output logic [3:0]  out_match_rank,
  output logic [3:0]  out_background_count,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_bg_threshold
);
  import gmpc_pkg::*;

  localparam int PIX_AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam int RANK_W = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

  // stage valids and ready chain
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  logic in_xfer;
  logic in_range;
  logic [31:0] pix_ext;
  logic [PIX_AW-1:0] pix_addr;

  // payload carried alongside the memory and logic stages
  logic [15:0] pix1_r, pix2_r, pix3_r;
  logic [7:0]  int1_r;
  logic [15:0] thr_r;

  entry_t                    wr_entry;
  entry_t                    rd_entry [NUM_COMPONENTS];
  logic [RANK_W-1:0]         rank2 [NUM_COMPONENTS];
  logic [NUM_COMPONENTS-1:0] match2;
  logic [15:0]               weight2 [NUM_COMPONENTS];

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign in_xfer  = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign pix_ext  = {16'h0000, in_pixel_index};
  assign pix_addr = pix_ext[PIX_AW-1:0];
  assign in_range = (pix_ext < 32'(NUM_PIXELS));

  assign wr_entry = '{ratio:   in_rank_ratio,
                      weight:  in_weight_value,
                      std_dev: in_std_value,
                      mean:    in_mean_value};

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      thr_r <= BG_THRESHOLD_RESET;
    end else begin
      if (rdy1) begin
        v1_r <= in_xfer && in_range && (in_req_type == REQ_CLASSIFY);
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_bg_threshold;
      end
    end
  end

  // pixel index and intensity ride along with the stages
  always_ff @(posedge clk) begin
    if (rdy1) begin
      pix1_r <= in_pixel_index;
      int1_r <= in_intensity;
    end
    if (rdy2) begin
      pix2_r <= pix1_r;
    end
    if (rdy3) begin
      pix3_r <= pix2_r;
    end
  end

  // stage 1: model banks, written on load transfers, read whenever stage 1 moves
  gmpc_model_mem #(
    .NUM_COMPONENTS (NUM_COMPONENTS),
    .NUM_PIXELS     (NUM_PIXELS)
  ) u_mem (
    .clk       (clk),
    .wr_en     (in_xfer && in_range && (in_req_type == REQ_LOAD)),
    .wr_comp   (in_component),
    .wr_addr   (pix_addr),
    .wr_data   (wr_entry),
    .rd_en     (rdy1),
    .rd_addr   (pix_addr),
    .rd_data_r (rd_entry)
  );

  // stage 2: ranking by ratio and match test
  gmpc_rank_match #(
    .NUM_COMPONENTS (NUM_COMPONENTS)
  ) u_rank (
    .clk       (clk),
    .en        (rdy2),
    .ent       (rd_entry),
    .intensity (int1_r),
    .rank_r    (rank2),
    .match_r   (match2),
    .weight_r  (weight2)
  );

  // stage 3: cumulative weight against the threshold and the decision
  gmpc_decide #(
    .NUM_COMPONENTS (NUM_COMPONENTS)
  ) u_decide (
    .clk          (clk),
    .en           (rdy3),
    .rank         (rank2),
    .match        (match2),
    .weight       (weight2),
    .threshold    (thr_r),
    .foreground_r (out_foreground),
    .match_rank_r (out_match_rank),
    .bg_count_r   (out_background_count)
  );

  assign out_valid     = v3_r;
  assign out_pixel_out = pix3_r;

endmodule

@@ hw/rtl/gmpc_model_mem.sv @@
// gmpc_model_mem: per-component banks of the mixture model, one entry per pixel
// depends on gmpc_pkg
module gmpc_model_mem #(
  parameter int NUM_COMPONENTS = 5,
  parameter int NUM_PIXELS     = 65536,
  localparam int PIX_AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [2:0]           wr_comp,
  input  logic [PIX_AW-1:0]    wr_addr,
  input  gmpc_pkg::entry_t     wr_data,
  input  logic                 rd_en,
  input  logic [PIX_AW-1:0]    rd_addr,
  output gmpc_pkg::entry_t     rd_data_r [NUM_COMPONENTS]
);
  import gmpc_pkg::*;

  for (genvar g = 0; g < NUM_COMPONENTS; g++) begin : g_bank
    entry_t bank [NUM_PIXELS];

    // contents undefined until loaded
    always_ff @(posedge clk) begin
      if (wr_en && (wr_comp == 3'(g))) begin
        bank[wr_addr] <= wr_data;
      end
      if (rd_en) begin
        rd_data_r[g] <= bank[rd_addr];
      end
    end
  end

endmodule

@@ hw/rtl/gmpc_rank_match.sv @@
// gmpc_rank_match: ranks the components of a pixel by ratio and tests each for a match
// depends on gmpc_pkg
module gmpc_rank_match #(
  parameter int NUM_COMPONENTS = 5,
  localparam int RANK_W = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1
) (
  input  logic                    clk,
  input  logic                    en,
  input  gmpc_pkg::entry_t        ent [NUM_COMPONENTS],
  input  logic [7:0]              intensity,
  output logic [RANK_W-1:0]       rank_r [NUM_COMPONENTS],
  output logic [NUM_COMPONENTS-1:0] match_r,
  output logic [15:0]             weight_r [NUM_COMPONENTS]
);
  import gmpc_pkg::*;

  logic [RANK_W-1:0]         rank_nxt [NUM_COMPONENTS];
  logic [NUM_COMPONENTS-1:0] match_nxt;
  logic [15:0]               inten;
  logic [15:0]               diff [NUM_COMPONENTS];
  logic [18:0]               lim  [NUM_COMPONENTS];

  assign inten = {intensity, 8'h00};

  // stable descending rank: ties go to the lower slot
  always_comb begin
    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      rank_nxt[i] = '0;
      for (int j = 0; j < NUM_COMPONENTS; j++) begin
        if ((ent[j].ratio > ent[i].ratio) || ((ent[j].ratio == ent[i].ratio) && (j < i))) begin
          rank_nxt[i] = rank_nxt[i] + RANK_W'(1);
        end
      end
    end
  end

  // within 2.5 std: |x - mean| * 2 <= std * 5
  always_comb begin
    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      diff[i] = (inten >= ent[i].mean) ? (inten - ent[i].mean) : (ent[i].mean - inten);
      lim[i]  = {3'b000, ent[i].std_dev} + {1'b0, ent[i].std_dev, 2'b00};
      match_nxt[i] = ({2'b00, diff[i], 1'b0} <= lim[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        rank_r[i]   <= rank_nxt[i];
        weight_r[i] <= ent[i].weight;
      end
      match_r <= match_nxt;
    end
  end

endmodule

@@ hw/rtl/gmpc_decide.sv @@
// gmpc_decide: cumulative weight per rank, background count, first match and the decision
// depends on gmpc_pkg
module gmpc_decide #(
  parameter int NUM_COMPONENTS = 5,
  localparam int RANK_W = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [RANK_W-1:0]         rank [NUM_COMPONENTS],
  input  logic [NUM_COMPONENTS-1:0] match,
  input  logic [15:0]               weight [NUM_COMPONENTS],
  input  logic [15:0]               threshold,
  output logic                      foreground_r,
  output logic [gmpc_pkg::CNT_W-1:0] match_rank_r,
  output logic [gmpc_pkg::CNT_W-1:0] bg_count_r
);
  import gmpc_pkg::*;

  logic [SUM_W-1:0]          prefix [NUM_COMPONENTS];
  logic [NUM_COMPONENTS-1:0] reach_pos;
  logic [NUM_COMPONENTS-1:0] match_pos;
  logic [CNT_W-1:0]          count_nxt;
  logic [CNT_W-1:0]          match_nxt;

  // weight sum up to and including each component's rank
  always_comb begin
    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      prefix[i] = '0;
      for (int j = 0; j < NUM_COMPONENTS; j++) begin
        if (rank[j] <= rank[i]) begin
          prefix[i] = prefix[i] + SUM_W'(weight[j]);
        end
      end
    end
  end

  // move flags to rank positions
  always_comb begin
    reach_pos = '0;
    match_pos = '0;
    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      if (prefix[i] >= SUM_W'(threshold)) begin
        reach_pos[rank[i]] = 1'b1;
      end
      if (match[i]) begin
        match_pos[rank[i]] = 1'b1;
      end
    end
  end

  // lowest set rank wins, none gives K+1
  always_comb begin
    count_nxt = CNT_W'(NUM_COMPONENTS + 1);
    match_nxt = CNT_W'(NUM_COMPONENTS + 1);
    for (int r = NUM_COMPONENTS - 1; r >= 0; r--) begin
      if (reach_pos[r]) begin
        count_nxt = CNT_W'(r + 1);
      end
      if (match_pos[r]) begin
        match_nxt = CNT_W'(r + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bg_count_r   <= count_nxt;
      match_rank_r <= match_nxt;
      foreground_r <= (count_nxt < match_nxt);
    end
  end

endmodule

@@ hw/rtl/gmpc_checker.sv @@
// gmpc_checker: port-level assertions for the mixture classifier, bound to the top level
// depends on gaussian_mixture_pixel_classifier
module gmpc_checker #(
  parameter int NUM_COMPONENTS = 5
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pixel_out,
  input logic        out_foreground,
  input logic [3:0]  out_match_rank,
  input logic [3:0]  out_background_count
);

  // no result straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_out) &&
                                $stable(out_match_rank) && $stable(out_background_count))
    else $error("waiting result changed");

  // ranks within one to K+1
  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_match_rank >= 4'd1) && (out_match_rank <= 4'(NUM_COMPONENTS + 1)) &&
                  (out_background_count >= 4'd1) &&
                  (out_background_count <= 4'(NUM_COMPONENTS + 1)))
    else $error("rank out of range");

  // decision agrees with the two ranks
  a_decision: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_foreground == (out_background_count < out_match_rank))
    else $error("foreground flag inconsistent");

endmodule

bind gaussian_mixture_pixel_classifier gmpc_checker #(
  .NUM_COMPONENTS (NUM_COMPONENTS)
) u_gmpc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_pixel_out        (out_pixel_out),
  .out_foreground       (out_foreground),
  .out_match_rank       (out_match_rank),
  .out_background_count (out_background_count)
);

@@ tb/gaussian_mixture_pixel_classifier_tb.sv @@
// gaussian_mixture_pixel_classifier_tb: self-checking bench for the mixture pixel classifier
// depends on gmpc_pkg and gaussian_mixture_pixel_classifier; predicts each result from its
// own copy of the model memory and bg_threshold and checks it field by field
module gaussian_mixture_pixel_classifier_tb;
  import gmpc_pkg::*;

  localparam int NUM_COMP      = 5;
  localparam int NUM_PIX       = 65536;
  localparam int WATCHDOG_MAX  = 2000;  // cycles with no transfer on any channel
  localparam int DRAIN_CYCLES  = 8;     // enough to empty the pipeline, with slack
  localparam int GAP_PERCENT   = 38;

  // one input transfer as the bench sees it
  typedef struct {
    logic        kind;
    logic [15:0] pixel;
    logic [2:0]  slot;
    logic [15:0] mean;
    logic [15:0] std_dev;
    logic [15:0] weight;
    logic [15:0] ratio;
    logic [7:0]  level;
  } request_t;

  // one classification result
  typedef struct {
    logic [15:0] pixel;
    logic        foreground;
    logic [3:0]  match_rank;
    logic [3:0]  bg_count;
  } verdict_t;

  // mirror of the model memory and threshold, plus the verdicts still owed by the block
  class pixel_verdict_board;
    entry_t      model [int];
    logic [15:0] threshold;
    verdict_t    pending [$];
    int          errors;

    function new();
      threshold = BG_THRESHOLD_RESET;
      errors    = 0;
    endfunction

    function int key_of(logic [15:0] pixel, int slot);
      return int'(pixel) * NUM_COMP + slot;
    endfunction

    // rank by ratio (descending, lower slot wins a tie), then count and match in rank order
    function verdict_t classify(logic [15:0] pixel, logic [7:0] level);
      entry_t      e [NUM_COMP];
      int          order [NUM_COMP];
      int          r;
      logic [19:0] sum;
      int unsigned inten;
      int unsigned diff;
      logic [3:0]  count;
      logic [3:0]  match;
      verdict_t    v;
      for (int i = 0; i < NUM_COMP; i++) e[i] = model[key_of(pixel, i)];
      for (int i = 0; i < NUM_COMP; i++) begin
        r = 0;
        for (int j = 0; j < NUM_COMP; j++) begin
          if (e[j].ratio > e[i].ratio || (e[j].ratio == e[i].ratio && j < i)) r++;
        end
        order[r] = i;
      end
      inten = {16'd0, level, 8'd0};
      sum   = '0;
      count = 4'(NUM_COMP + 1);
      match = 4'(NUM_COMP + 1);
      for (int i = 0; i < NUM_COMP; i++) begin
        entry_t c;
        c = e[order[i]];
        diff = (inten >= c.mean) ? inten - c.mean : c.mean - inten;
        sum  = sum + c.weight;
        if (count > NUM_COMP && sum >= {4'd0, threshold}) count = 4'(i + 1);
        if (match > NUM_COMP && diff * 2 <= int'(c.std_dev) * 5) match = 4'(i + 1);
      end
      v.pixel      = pixel;
      v.foreground = (count < match);
      v.match_rank = match;
      v.bg_count   = count;
      return v;
    endfunction

    // an accepted input: a load updates the mirror, a classify owes a verdict
    function void note_request(request_t q);
      entry_t e;
      if (q.kind == REQ_LOAD) begin
        if (q.slot < NUM_COMP && q.pixel < NUM_PIX) begin
          e.mean    = q.mean;
          e.std_dev = q.std_dev;
          e.weight  = q.weight;
          e.ratio   = q.ratio;
          model[key_of(q.pixel, q.slot)] = e;
        end
      end else if (q.pixel < NUM_PIX) begin
        pending = {pending, classify(q.pixel, q.level)};
      end
    endfunction

    function void report(string what, int expected, int actual);
      if (expected != actual) begin
        $display("%0t: %s expected %0d actual %0d", $time, what, expected, actual);
        errors++;
      end
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result expected none actual pixel %0d", $time, got.pixel);
        errors++;
        return;
      end
      want = pending.pop_front();
      report("pixel_out", want.pixel, got.pixel);
      report("foreground", want.foreground, got.foreground);
      report("match_rank", want.match_rank, got.match_rank);
      report("background_count", want.bg_count, got.bg_count);
    endfunction
  endclass

  // dut ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = REQ_LOAD;
  logic [15:0] in_pixel_index = '0;
  logic [2:0]  in_component = '0;
  logic [15:0] in_mean_value = '0;
  logic [15:0] in_std_value = '0;
  logic [15:0] in_weight_value = '0;
  logic [15:0] in_rank_ratio = '0;
  logic [7:0]  in_intensity = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_pixel_out;
  logic        out_foreground;
  logic [3:0]  out_match_rank;
  logic [3:0]  out_background_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_bg_threshold = '0;

  pixel_verdict_board board = new();
  bit   gaps_on = 1'b1;   // cleared for the stretch with no idling on either side
  int   live_pixels [$];  // pixels with all components loaded, safe to classify
  int   quiet_cycles = 0;

  gaussian_mixture_pixel_classifier #(
    .NUM_COMPONENTS(NUM_COMP),
    .NUM_PIXELS    (NUM_PIX)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_pixel_index      (in_pixel_index),
    .in_component        (in_component),
    .in_mean_value       (in_mean_value),
    .in_std_value        (in_std_value),
    .in_weight_value     (in_weight_value),
    .in_rank_ratio       (in_rank_ratio),
    .in_intensity        (in_intensity),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pixel_out       (out_pixel_out),
    .out_foreground      (out_foreground),
    .out_match_rank      (out_match_rank),
    .out_background_count(out_background_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_bg_threshold    (cfg_bg_threshold)
  );

  always #2 clk = ~clk;

  // result side: random back-pressure, changed only at the falling edge
  always @(negedge clk) begin
    out_ready <= gaps_on ? ($urandom_range(0, 99) >= GAP_PERCENT) : 1'b1;
  end

  // sample at the rising edge, before the block's registers move
  always @(posedge clk) begin
    verdict_t got;
    if (rst_n && out_valid && out_ready) begin
      got.pixel      = out_pixel_out;
      got.foreground = out_foreground;
      got.match_rank = out_match_rank;
      got.bg_count   = out_background_count;
      board.check_verdict(got);
    end
  end

  // watchdog: too long without any transfer means the block hung
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic request_t make_load(logic [15:0] pixel, logic [2:0] slot, logic [15:0] mean,
                                         logic [15:0] sd, logic [15:0] weight,
                                         logic [15:0] ratio);
    request_t q;
    q.kind    = REQ_LOAD;
    q.pixel   = pixel;
    q.slot    = slot;
    q.mean    = mean;
    q.std_dev = sd;
    q.weight  = weight;
    q.ratio   = ratio;
    q.level   = 8'($urandom);  // don't care for a load, but keep the bits moving
    return q;
  endfunction

  function automatic request_t make_classify(logic [15:0] pixel, logic [7:0] level);
    request_t q;
    q = make_load(pixel, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
    q.kind  = REQ_CLASSIFY;
    q.level = level;
    return q;
  endfunction

  // random component content, biased toward narrow stds, ratio ties and boundary weights
  function automatic request_t random_load(logic [15:0] pixel, logic [2:0] slot);
    logic [15:0] mean;
    logic [15:0] sd;
    logic [15:0] weight;
    logic [15:0] ratio;
    mean = 16'($urandom);
    case ($urandom_range(0, 3))
      0:       sd = 16'($urandom);
      1:       sd = '0;
      default: sd = 16'($urandom_range(0, 16'h0600));
    endcase
    case ($urandom_range(0, 5))
      0:       weight = '0;
      1:       weight = 16'hFFFF;
      2, 3:    weight = 16'($urandom);
      default: weight = 16'($urandom_range(0, 16'h4000));
    endcase
    ratio = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    return make_load(pixel, slot, mean, sd, weight, ratio);
  endfunction

  // entered and left at a falling edge; valid stays high across back-to-back transfers
  task automatic send_request(input request_t q);
    while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_req_type     = q.kind;
    in_pixel_index  = q.pixel;
    in_component    = q.slot;
    in_mean_value   = q.mean;
    in_std_value    = q.std_dev;
    in_weight_value = q.weight;
    in_rank_ratio   = q.ratio;
    in_intensity    = q.level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(q);
    @(negedge clk);
  endtask

  // hold the input side until every owed verdict has come back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  // threshold writes only with the block idle; loads leave no result, so wait out the pipe
  task automatic write_threshold(input logic [15:0] value);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid        = 1'b1;
    cfg_bg_threshold = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.threshold = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // a well-formed model: all components of one pixel, then it may be classified
  task automatic load_pixel(input logic [15:0] pixel);
    for (int c = 0; c < NUM_COMP; c++) send_request(random_load(pixel, 3'(c)));
    live_pixels = {live_pixels, int'(pixel)};
  endtask

  // mostly classifies of loaded pixels, with reloads, fresh models and ignored slots mixed in
  task automatic run_random(input int budget);
    int          left;
    int          pick;
    logic [15:0] pixel;
    logic [7:0]  level;
    left = budget;
    while (left > 0) begin
      pick  = $urandom_range(0, 99);
      pixel = 16'(live_pixels[$urandom_range(0, live_pixels.size() - 1)]);
      if (pick < 10 || live_pixels.size() < 4) begin
        load_pixel(16'($urandom));
        left -= NUM_COMP;
      end else if (pick < 65) begin
        // half the time aim the intensity near one component's mean so matches happen
        if ($urandom_range(0, 1)) begin
          level = board.model[board.key_of(pixel, $urandom_range(0, NUM_COMP - 1))].mean[15:8];
          level = level + 8'($urandom_range(0, 4)) - 8'd2;
        end else begin
          level = 8'($urandom);
        end
        send_request(make_classify(pixel, level));
        left--;
      end else if (pick < 90) begin
        send_request(random_load(pixel, 3'($urandom_range(0, NUM_COMP - 1))));
        left--;
      end else if (pick < 95) begin
        // slot past the last component: dropped by the block, not counted
        send_request(random_load(pixel, 3'($urandom_range(NUM_COMP, 7))));
      end else begin
        // partial model on some other pixel, never classified unless fully loaded later
        send_request(random_load(16'($urandom), 3'($urandom_range(0, NUM_COMP - 1))));
        left--;
      end
    end
  endtask

  initial begin
    logic [15:0] phase_threshold [6];
    phase_threshold = '{16'd0, 16'hFFFF, 16'($urandom), 16'd1, 16'($urandom), 16'd32768};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, default threshold of one half
    // pixel 0: all ratios tied so rank follows slot order; zero and full-scale fields
    send_request(make_load(16'd0, 3'd0, 16'h0000, 16'h0000, 16'hFFFF, 16'd7));
    send_request(make_load(16'd0, 3'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd7));
    send_request(make_load(16'd0, 3'd2, 16'h8000, 16'h0100, 16'h0000, 16'd7));
    send_request(make_load(16'd0, 3'd3, 16'h4000, 16'h0000, 16'h0001, 16'd7));
    send_request(make_load(16'd0, 3'd4, 16'hFF00, 16'h0066, 16'h7FFF, 16'd7));
    live_pixels = {live_pixels, int'(0)};
    send_request(make_classify(16'd0, 8'd0));    // exact hit with zero std
    send_request(make_classify(16'd0, 8'd255));
    // slots beyond the mixture must not touch the model
    send_request(make_load(16'd0, 3'd5, 16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFF));
    send_request(make_load(16'd0, 3'd7, 16'h5555, 16'hAAAA, 16'hFFFF, 16'hFFFF));
    send_request(make_classify(16'd0, 8'd128));
    // last pixel: zero weights never reach the threshold, narrow stds rarely match
    for (int c = 0; c < NUM_COMP; c++) begin
      send_request(make_load(16'hFFFF, 3'(c), 16'((c + 1) * 256), 16'h0000, 16'h0000,
                             16'(c)));
    end
    live_pixels = {live_pixels, int'(16'hFFFF)};
    send_request(make_classify(16'hFFFF, 8'd200)); // neither count nor match
    send_request(make_classify(16'hFFFF, 8'd3));   // match only
    // threshold reached in two ranks, match only in the last rank: foreground
    send_request(make_load(16'h5AA5, 3'd0, 16'h0000, 16'h0010, 16'h4000, 16'hFFFF));
    send_request(make_load(16'h5AA5, 3'd1, 16'h0000, 16'h0010, 16'h4000, 16'd100));
    send_request(make_load(16'h5AA5, 3'd2, 16'h0000, 16'h0010, 16'h4000, 16'hFFFF));
    send_request(make_load(16'h5AA5, 3'd3, 16'h7800, 16'h0100, 16'h4000, 16'd0));
    send_request(make_load(16'h5AA5, 3'd4, 16'h0000, 16'h0010, 16'h4000, 16'd5));
    live_pixels = {live_pixels, int'(16'h5AA5)};
    send_request(make_classify(16'h5AA5, 8'd120));
    send_request(make_classify(16'h5AA5, 8'd255));

    // random phases, each under its own threshold, zero and full scale among them
    for (int ph = 0; ph < 6; ph++) begin
      write_threshold(phase_threshold[ph]);
      gaps_on = (ph != 3);
      if (ph == 1) begin
        run_random(85);
        wait_drained();  // sender holds until the block has emptied
        run_random(85);
      end else begin
        run_random(170);
      end
    end
    gaps_on = 1'b1;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/gmpc_pkg.sv
hw/rtl/gmpc_model_mem.sv
hw/rtl/gmpc_rank_match.sv
hw/rtl/gmpc_decide.sv
hw/rtl/gaussian_mixture_pixel_classifier.sv
hw/rtl/gmpc_checker.sv
tb/gaussian_mixture_pixel_classifier_tb.sv
